/* hdl/avcc2ab_pkg.sv */
// ----------------------------------------------------------------------------
// avcc2ab_pkg
// Shared types, codes and helpers for the avcC to Annex B converter.
// ----------------------------------------------------------------------------
`default_nettype none

package avcc2ab_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_XDATA  = 2'd1,
      KIND_EOS    = 2'd2,
      KIND_FILL   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NAL_OVERRUN = 2'd1,
      ST_XDATA_SHORT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE        = 4'd0,
      PH_X_PASS      = 4'd1,
      PH_X_HDR       = 4'd2,
      PH_X_SIZE_HI   = 4'd3,
      PH_X_SIZE_LO   = 4'd4,
      PH_X_PAYLOAD   = 4'd5,
      PH_X_PPS_COUNT = 4'd6,
      PH_X_DONE      = 4'd7,
      PH_S_PASS      = 4'd8,
      PH_S_LEN       = 4'd9,
      PH_S_PAYLOAD   = 4'd10
   } phase_type;

   // what the back end emits for one transaction
   typedef enum logic [2:0] {
      OP_STATUS = 3'd0,
      OP_BYTE   = 3'd1,
      OP_START  = 3'd2,
      OP_EOS    = 3'd3,
      OP_FILL   = 3'd4
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       done;
      status_type status;
   } cmd_type;

   localparam logic [7:0] START_LAST_BYTE = 8'h01;
   localparam logic [7:0] EOS_NAL_BYTE    = 8'h0b;
   localparam logic [7:0] FILL_NAL_BYTE   = 8'h0c;
   localparam logic [7:0] FILL_TRAIL_BYTE = 8'h80;
   localparam logic [7:0] SPS_COUNT_MASK  = 8'h1f;
   localparam logic [7:0] LEN_SIZE_MASK   = 8'h03;

   function automatic phase_type next_header_phase(input logic [7:0] hdrs_left,
                                                   input logic       pps_section);
      phase_type p;
      if (hdrs_left != 8'd0) begin
         p = PH_X_SIZE_HI;
      end else if (!pps_section) begin
         p = PH_X_PPS_COUNT;
      end else begin
         p = PH_X_DONE;
      end
      return p;
   endfunction

   function automatic logic [2:0] op_length(input op_type op);
      logic [2:0] n;
      unique case (op)
         OP_START: n = 3'd4;
         OP_EOS:   n = 3'd5;
         OP_FILL:  n = 3'd6;
         default:  n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] op_byte(input op_type     op,
                                          input logic [2:0] idx,
                                          input logic [7:0] data);
      logic [7:0] v;
      v = 8'h00;
      unique case (op)
         OP_BYTE:   v = data;
         OP_STATUS: v = 8'h00;
         default: begin
            case (idx)
               3'd3:    v = START_LAST_BYTE;
               3'd4:    v = (op == OP_EOS) ? EOS_NAL_BYTE : FILL_NAL_BYTE;
               3'd5:    v = FILL_TRAIL_BYTE;
               default: v = 8'h00;
            endcase
         end
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* hdl/avcc2ab_front.sv */
// ----------------------------------------------------------------------------
// avcc2ab_front
// Parses input bytes, tracks the framing state and issues one command per
// transaction that produces results.
// ----------------------------------------------------------------------------
`default_nettype none

module avcc2ab_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     accept,
   input  wire  [7:0]              data_byte,
   input  wire  [1:0]              packet_kind,
   input  wire                     last_in_packet,
   output logic                    push,
   output avcc2ab_pkg::cmd_type    cmd
);

   logic                    avcc_ff, avcc_in;
   logic [2:0]              lfb_ff, lfb_in;
   avcc2ab_pkg::phase_type  phase_ff, phase_in;
   logic [31:0]             acc_ff, acc_in;
   logic [31:0]             left_ff, left_in;
   logic [7:0]              hdrs_ff, hdrs_in;
   logic [2:0]              idx_ff, idx_in;
   logic                    pps_ff, pps_in;

   avcc2ab_pkg::kind_type   kind;
   avcc2ab_pkg::op_type     op;
   logic                    done;
   avcc2ab_pkg::status_type status;
   logic [31:0]             acc_next;
   logic [31:0]             left_dec;
   logic [2:0]              idx_next;
   logic [2:0]              need;

   assign kind     = avcc2ab_pkg::kind_type'(packet_kind);
   assign acc_next = {acc_ff[23:0], data_byte};
   assign left_dec = left_ff - 32'd1;

   always_comb begin
      avcc_in  = avcc_ff;
      lfb_in   = lfb_ff;
      phase_in = phase_ff;
      acc_in   = acc_ff;
      left_in  = left_ff;
      hdrs_in  = hdrs_ff;
      idx_in   = idx_ff;
      pps_in   = pps_ff;
      op       = avcc2ab_pkg::OP_STATUS;
      done     = 1'b0;
      status   = avcc2ab_pkg::ST_OK;
      idx_next = idx_ff + 3'd1;
      need     = (lfb_ff == 3'd0) ? 3'd1 : lfb_ff;

      if (kind == avcc2ab_pkg::KIND_EOS || kind == avcc2ab_pkg::KIND_FILL) begin
         phase_in = avcc2ab_pkg::PH_IDLE;
         acc_in   = 32'd0;
         left_in  = 32'd0;
         idx_in   = 3'd0;
         op       = (kind == avcc2ab_pkg::KIND_EOS) ? avcc2ab_pkg::OP_EOS
                                                    : avcc2ab_pkg::OP_FILL;
         done     = 1'b1;
      end else begin
         if (kind == avcc2ab_pkg::KIND_XDATA) begin
            if (phase_ff < avcc2ab_pkg::PH_X_PASS || phase_ff > avcc2ab_pkg::PH_X_DONE) begin
               avcc_in = (data_byte == 8'd1);
               if (data_byte == 8'd1) begin
                  phase_in = avcc2ab_pkg::PH_X_HDR;
                  idx_in   = 3'd1;
               end else begin
                  phase_in = avcc2ab_pkg::PH_X_PASS;
                  op       = avcc2ab_pkg::OP_BYTE;
               end
            end else begin
               unique case (phase_ff)
                  avcc2ab_pkg::PH_X_PASS: begin
                     op = avcc2ab_pkg::OP_BYTE;
                  end
                  avcc2ab_pkg::PH_X_HDR: begin
                     if (idx_ff == 3'd4) begin
                        lfb_in = {1'b0, data_byte[1:0] & avcc2ab_pkg::LEN_SIZE_MASK[1:0]}
                                 + 3'd1;
                     end
                     if (idx_ff == 3'd5) begin
                        hdrs_in  = data_byte & avcc2ab_pkg::SPS_COUNT_MASK;
                        pps_in   = 1'b0;
                        idx_in   = 3'd0;
                        phase_in = avcc2ab_pkg::next_header_phase(
                                      data_byte & avcc2ab_pkg::SPS_COUNT_MASK, 1'b0);
                     end else begin
                        idx_in = idx_next;
                     end
                  end
                  avcc2ab_pkg::PH_X_SIZE_HI: begin
                     hdrs_in  = hdrs_ff - 8'd1;
                     acc_in   = {24'd0, data_byte};
                     phase_in = avcc2ab_pkg::PH_X_SIZE_LO;
                  end
                  avcc2ab_pkg::PH_X_SIZE_LO: begin
                     op      = avcc2ab_pkg::OP_START;
                     left_in = {16'd0, acc_next[15:0]};
                     acc_in  = 32'd0;
                     if (acc_next[15:0] == 16'd0) begin
                        phase_in = avcc2ab_pkg::next_header_phase(hdrs_ff, pps_ff);
                     end else begin
                        phase_in = avcc2ab_pkg::PH_X_PAYLOAD;
                     end
                  end
                  avcc2ab_pkg::PH_X_PAYLOAD: begin
                     op      = avcc2ab_pkg::OP_BYTE;
                     left_in = left_dec;
                     if (left_dec == 32'd0) begin
                        phase_in = avcc2ab_pkg::next_header_phase(hdrs_ff, pps_ff);
                     end
                  end
                  avcc2ab_pkg::PH_X_PPS_COUNT: begin
                     pps_in   = 1'b1;
                     hdrs_in  = data_byte;
                     phase_in = avcc2ab_pkg::next_header_phase(data_byte, 1'b1);
                  end
                  default: begin
                  end
               endcase
            end
         end else begin
            if (phase_ff < avcc2ab_pkg::PH_S_PASS || phase_ff > avcc2ab_pkg::PH_S_PAYLOAD) begin
               // new sample packet: parse from a clean slate
               phase_in = avcc_ff ? avcc2ab_pkg::PH_S_LEN : avcc2ab_pkg::PH_S_PASS;
               if (avcc_ff) begin
                  acc_in = {24'd0, data_byte};
                  if (need <= 3'd1) begin
                     op     = avcc2ab_pkg::OP_START;
                     left_in = {24'd0, data_byte};
                     acc_in = 32'd0;
                     idx_in = 3'd0;
                     if (data_byte != 8'd0) begin
                        phase_in = avcc2ab_pkg::PH_S_PAYLOAD;
                     end
                  end else begin
                     left_in = 32'd0;
                     idx_in  = 3'd1;
                  end
               end else begin
                  acc_in  = 32'd0;
                  left_in = 32'd0;
                  idx_in  = 3'd0;
                  op      = avcc2ab_pkg::OP_BYTE;
               end
            end else begin
               unique case (phase_ff)
                  avcc2ab_pkg::PH_S_LEN: begin
                     acc_in = acc_next;
                     idx_in = idx_next;
                     if (idx_next >= need) begin
                        op      = avcc2ab_pkg::OP_START;
                        left_in = acc_next;
                        acc_in  = 32'd0;
                        idx_in  = 3'd0;
                        if (acc_next != 32'd0) begin
                           phase_in = avcc2ab_pkg::PH_S_PAYLOAD;
                        end
                     end
                  end
                  avcc2ab_pkg::PH_S_PAYLOAD: begin
                     op      = avcc2ab_pkg::OP_BYTE;
                     left_in = left_dec;
                     if (left_dec == 32'd0) begin
                        phase_in = avcc2ab_pkg::PH_S_LEN;
                     end
                  end
                  default: begin
                     op = avcc2ab_pkg::OP_BYTE;
                  end
               endcase
            end
         end

         if (last_in_packet) begin
            done = 1'b1;
            if (kind == avcc2ab_pkg::KIND_XDATA) begin
               status = (phase_in == avcc2ab_pkg::PH_X_PASS ||
                         phase_in == avcc2ab_pkg::PH_X_DONE) ? avcc2ab_pkg::ST_OK
                                                            : avcc2ab_pkg::ST_XDATA_SHORT;
            end else begin
               status = (phase_in == avcc2ab_pkg::PH_S_PAYLOAD) ? avcc2ab_pkg::ST_NAL_OVERRUN
                                                               : avcc2ab_pkg::ST_OK;
            end
            phase_in = avcc2ab_pkg::PH_IDLE;
            acc_in   = 32'd0;
            left_in  = 32'd0;
            idx_in   = 3'd0;
         end
      end
   end

   assign push        = accept && (op != avcc2ab_pkg::OP_STATUS || done);
   assign cmd.op      = op;
   assign cmd.data    = data_byte;
   assign cmd.done    = done;
   assign cmd.status  = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         avcc_ff  <= 1'b0;
         lfb_ff   <= 3'd0;
         phase_ff <= avcc2ab_pkg::PH_IDLE;
         acc_ff   <= 32'd0;
         left_ff  <= 32'd0;
         hdrs_ff  <= 8'd0;
         idx_ff   <= 3'd0;
         pps_ff   <= 1'b0;
      end else if (accept) begin
         avcc_ff  <= avcc_in;
         lfb_ff   <= lfb_in;
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         hdrs_ff  <= hdrs_in;
         idx_ff   <= idx_in;
         pps_ff   <= pps_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/avcc2ab_queue.sv */
// ----------------------------------------------------------------------------
// avcc2ab_queue
// Small command FIFO between the parser and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module avcc2ab_queue #(
   parameter int unsigned DEPTH = avcc2ab_pkg::QUEUE_DEPTH
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  avcc2ab_pkg::cmd_type    push_cmd,
   input  wire                     pop,
   output logic                    full,
   output logic                    not_empty,
   output avcc2ab_pkg::cmd_type    head
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   // entries shift toward slot 0 on pop; slot 0 is the head
   avcc2ab_pkg::cmd_type slot_ff [DEPTH];
   avcc2ab_pkg::cmd_type slot_in [DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] fill_idx;
   logic          do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[0];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign fill_idx  = do_pop ? count_ff - CW'(1) : count_ff;

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (do_pop) begin
         for (int i = 0; i < int'(DEPTH) - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
      if (do_push) begin
         slot_in[fill_idx[PW-1:0]] = push_cmd;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

/* hdl/avcc2ab_back.sv */
// ----------------------------------------------------------------------------
// avcc2ab_back
// Expands queued commands into output bytes, one per cycle while rsp_stall
// is low, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module avcc2ab_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     cmd_valid,
   input  avcc2ab_pkg::cmd_type    cmd,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_byte_valid,
   output logic                    rsp_last_of_run,
   output logic                    rsp_packet_done,
   output logic [1:0]              rsp_status
);

   logic       valid_ff, valid_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] byte_ff;
   logic       bval_ff, last_ff, done_ff;
   logic [1:0] status_ff;
   logic       load, emit, fin;

   assign load = !valid_ff || !rsp_stall;
   assign emit = load && cmd_valid;
   assign fin  = (idx_ff == avcc2ab_pkg::op_length(cmd.op) - 3'd1);
   assign pop  = emit && fin;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = cmd_valid;
      end
      if (emit) begin
         idx_in = fin ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff   <= avcc2ab_pkg::op_byte(cmd.op, idx_ff, cmd.data);
         bval_ff   <= (cmd.op != avcc2ab_pkg::OP_STATUS);
         last_ff   <= fin;
         done_ff   <= fin && cmd.done;
         status_ff <= (fin && cmd.done) ? cmd.status : avcc2ab_pkg::ST_OK;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bval_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_packet_done = done_ff;
   assign rsp_status      = status_ff;

endmodule

`default_nettype wire

/* hdl/avcc_to_annexb_converter_core.sv */
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter_core
// Converts avcC length-prefixed H.264 NAL units to Annex B byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one input byte (or marker) per transaction, with its packet kind
//            and an end-of-packet flag. req_stall rises when the command
//            queue is full.
//   rsp_*  : zero to six result transactions per input transaction, in order.
//            rsp_byte_valid low marks a status-only result; rsp_status is
//            final on the result with rsp_packet_done set.
//   A transaction's command is registered in the command queue, and its
//   first result then in the output register, once the queue ahead drains.
//   Throughput: one input per cycle while each input yields at most one
//   result and rsp_stall stays low. The output sequencer emits one result per
//   cycle while not stalled; a start code is 4 results and end-of-stream /
//   filler units 5 / 6, and the queue (QUEUE_DEPTH entries) absorbs bursts.
//   Reset clears the framing state (byte-stream pass-through mode), the
//   queue and the output register. While rsp_stall is high a valid result in
//   the output register holds; the front keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module avcc_to_annexb_converter_core #(
   parameter int unsigned QUEUE_DEPTH = avcc2ab_pkg::QUEUE_DEPTH
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire  [7:0]   req_data_byte,
   input  wire  [1:0]   req_packet_kind,
   input  wire          req_last_in_packet,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_byte_valid,
   output logic         rsp_last_of_run,
   output logic         rsp_packet_done,
   output logic [1:0]   rsp_status
);

   logic                 accept;
   logic                 push, pop, full, not_empty;
   avcc2ab_pkg::cmd_type push_cmd, head_cmd;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   avcc2ab_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_data_byte),
      .packet_kind    (req_packet_kind),
      .last_in_packet (req_last_in_packet),
      .push           (push),
      .cmd            (push_cmd)
   );

   avcc2ab_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head_cmd)
   );

   avcc2ab_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (not_empty),
      .cmd             (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_packet_done (rsp_packet_done),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

/* hdl/avcc2ab_checker.sv */
// ----------------------------------------------------------------------------
// avcc2ab_checker
// Port-level checks on the converter's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module avcc2ab_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [7:0]  rsp_out_byte,
   input wire        rsp_byte_valid,
   input wire        rsp_last_of_run,
   input wire        rsp_packet_done,
   input wire [1:0]  rsp_status
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte))
      else $error("result changed while stalled");

   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last_of_run && rsp_packet_done &&
                                       rsp_out_byte == 8'h00)
      else $error("status-only result malformed");

   a_status_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != avcc2ab_pkg::ST_OK |-> rsp_packet_done)
      else $error("status reported before packet end");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_done |-> rsp_last_of_run)
      else $error("packet done not on last result of run");

endmodule

bind avcc_to_annexb_converter_core avcc2ab_checker u_avcc2ab_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_byte_valid  (rsp_byte_valid),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_packet_done (rsp_packet_done),
   .rsp_status      (rsp_status)
);

`default_nettype wire
